// ----- hw/rtl/unix_time_to_calendar_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the UTC calendar converter
// Shared assertion forms, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef UNIX_TIME_TO_CALENDAR_DEFINES_SVH
`define UNIX_TIME_TO_CALENDAR_DEFINES_SVH

// Plain clocked assertion.
`define UTC_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is switched off while the active-low reset is low.
`define UTC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  `UTC_ASSERT(lbl, clk, disable iff (!rstn) prop, msg)

`endif

// ----- hw/rtl/utc_pkg.sv -----
// ----------------------------------------------------------------------------
// UTC calendar converter package
// Field types, reciprocal constants and the month start table.
// ----------------------------------------------------------------------------
`default_nettype none

package utc_pkg;

  typedef logic [30:0] epoch_t;
  typedef logic [10:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minsec_t;
  typedef logic [8:0]  doy_t;

  typedef struct packed {
    month_t month;
    day_t   day;
  } md_t;

  // Division of seconds by 86400 is done as (t >> 7) / 675 by reciprocal.
  localparam logic [24:0] DayRecip    = 25'd25451659;
  localparam logic [16:0] SecsPerDay  = 17'd86400;

  // Day count is shifted to 1969-01-01 so that four-year blocks end in a leap year.
  localparam logic [14:0] EpochShift  = 15'd365;
  localparam logic [15:0] QuadRecip   = 16'd45934;
  localparam logic [10:0] QuadDays    = 11'd1461;
  localparam logic [8:0]  DaysCommon  = 9'd365;
  localparam year_t       BaseYear    = 11'd1969;

  // Hour is (sod >> 4) / 225, minute is (rem >> 2) / 15, both by reciprocal.
  localparam logic [12:0] HourRecip   = 13'd4661;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [10:0] MinRecip    = 11'd1093;
  localparam logic [5:0]  SecsPerMin  = 6'd60;

  function automatic doy_t month_start(input month_t idx, input logic leap);
    doy_t base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/utc_month_lookup.sv -----
// ----------------------------------------------------------------------------
// UTC month lookup
// Turns a zero-based day of year into month and day of month.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_month_lookup (
  input  utc_pkg::doy_t doy_i,
  input  logic          leap_i,
  output utc_pkg::md_t  md_o
);
  import utc_pkg::*;

  month_t idx;
  doy_t   offset;

  always_comb begin
    idx = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy_i >= month_start(4'(m), leap_i)) begin
        idx = 4'(m);
      end
    end
    offset   = doy_i - month_start(idx, leap_i);
    md_o.month = idx + 4'd1;
    md_o.day   = offset[4:0] + 5'd1;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/unix_time_to_calendar.sv -----
// ----------------------------------------------------------------------------
// UTC calendar converter
// Throughput is one word per cycle unless the output stalls; each of the seven
// stages holds one word.
// A stage moves on when the stage after it is empty or moving.
// Reset clears the stage valid flags only; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_time_to_calendar (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  utc_pkg::epoch_t  epoch_seconds_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output utc_pkg::year_t   cal_year_o,
  output utc_pkg::month_t  cal_month_o,
  output utc_pkg::day_t    cal_day_o,
  output utc_pkg::hour_t   hour_of_day_o,
  output utc_pkg::minsec_t minute_of_hour_o,
  output utc_pkg::minsec_t second_of_minute_o
);
  import utc_pkg::*;

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0] valid_q, valid_d, valid_in, rdy, ld;

  always_comb begin
    rdy[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    valid_in = {valid_q[NumStages-2:0], in_valid_i};
    ld       = rdy & valid_in;
    valid_d  = (rdy & valid_in) | (~rdy & valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NumStages-1];

  // Stage 1: input register.
  epoch_t t1_q;
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      t1_q <= epoch_seconds_i;
    end
  end

  // Stage 2: whole days.
  logic [48:0] day_prod;
  logic [14:0] days2_q;
  logic [16:0] tlo2_q;
  assign day_prod = 49'(t1_q[30:7]) * 49'(DayRecip);
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      days2_q <= day_prod[48:34];
      tlo2_q  <= t1_q[16:0];
    end
  end

  // Stage 3: seconds of day and four-year block.
  logic [31:0] day_secs;
  logic [14:0] dp;
  logic [30:0] quad_prod;
  logic [16:0] sod3_q;
  logic [14:0] dp3_q;
  logic [4:0]  q3_q;
  assign day_secs  = 32'(days2_q) * 32'(SecsPerDay);
  assign dp        = days2_q + EpochShift;
  assign quad_prod = 31'(dp) * 31'(QuadRecip);
  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      sod3_q <= tlo2_q - day_secs[16:0];
      dp3_q  <= dp;
      q3_q   <= quad_prod[30:26];
    end
  end

  // Stage 4: hour and day within the block.
  logic [25:0] hour_prod;
  logic [15:0] quad_base;
  logic [14:0] r_full;
  hour_t       hour4_q;
  logic [16:0] sod4_q;
  logic [10:0] r4_q;
  logic [4:0]  q4_q;
  assign hour_prod = 26'(sod3_q[16:4]) * 26'(HourRecip);
  assign quad_base = 16'(q3_q) * 16'(QuadDays);
  assign r_full    = dp3_q - quad_base[14:0];
  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      hour4_q <= hour_prod[24:20];
      sod4_q  <= sod3_q;
      r4_q    <= r_full[10:0];
      q4_q    <= q3_q;
    end
  end

  // Stage 5: seconds of hour, year and day of year.
  logic [16:0] hour_secs;
  logic [1:0]  yb;
  logic [10:0] yb_days;
  logic [10:0] doy_full;
  hour_t       hour5_q;
  logic [11:0] rem5_q;
  year_t       year5_q;
  logic        leap5_q;
  doy_t        doy5_q;
  assign hour_secs = 17'(hour4_q) * 17'(SecsPerHour);
  always_comb begin
    if (r4_q >= 11'(3 * 365)) begin
      yb = 2'd3;
    end else if (r4_q >= 11'(2 * 365)) begin
      yb = 2'd2;
    end else if (r4_q >= 11'(DaysCommon)) begin
      yb = 2'd1;
    end else begin
      yb = 2'd0;
    end
    yb_days  = 11'(yb) * 11'(DaysCommon);
    doy_full = r4_q - yb_days;
  end
  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      hour5_q <= hour4_q;
      rem5_q  <= sod4_q[11:0] - hour_secs[11:0];
      year5_q <= BaseYear + {4'd0, q4_q, 2'b00} + 11'(yb);
      leap5_q <= (yb == 2'd3);
      doy5_q  <= doy_full[8:0];
    end
  end

  // Stage 6: month, day and minute.
  md_t         md;
  logic [20:0] min_prod;
  hour_t       hour6_q;
  logic [11:0] rem6_q;
  year_t       year6_q;
  md_t         md6_q;
  minsec_t     minute6_q;
  utc_month_lookup u_month_lookup (
    .doy_i  (doy5_q),
    .leap_i (leap5_q),
    .md_o   (md)
  );
  assign min_prod = 21'(rem5_q[11:2]) * 21'(MinRecip);
  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      hour6_q   <= hour5_q;
      rem6_q    <= rem5_q;
      year6_q   <= year5_q;
      md6_q     <= md;
      minute6_q <= min_prod[19:14];
    end
  end

  // Stage 7: seconds and result register.
  logic [11:0] min_secs;
  logic [11:0] sec_full;
  assign min_secs = 12'(minute6_q) * 12'(SecsPerMin);
  assign sec_full = rem6_q - min_secs;
  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      cal_year_o         <= year6_q;
      cal_month_o        <= md6_q.month;
      cal_day_o          <= md6_q.day;
      hour_of_day_o      <= hour6_q;
      minute_of_hour_o   <= minute6_q;
      second_of_minute_o <= sec_full[5:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/utc_checker.sv -----
// ----------------------------------------------------------------------------
// UTC calendar converter checker
// Port-level checks of result ranges, calendar rules and flow control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unix_time_to_calendar_defines.svh"

module utc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input utc_pkg::epoch_t  epoch_seconds_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input utc_pkg::year_t   cal_year_o,
  input utc_pkg::month_t  cal_month_o,
  input utc_pkg::day_t    cal_day_o,
  input utc_pkg::hour_t   hour_of_day_o,
  input utc_pkg::minsec_t minute_of_hour_o,
  input utc_pkg::minsec_t second_of_minute_o
);

  logic in_seen;
  assign in_seen = in_valid_i && (epoch_seconds_i == epoch_seconds_i);

  `UTC_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(cal_year_o) && $stable(cal_month_o) && $stable(cal_day_o) && $stable(second_of_minute_o), "result word changed while stalled")

  `UTC_ASSERT_RST(a_ranges, clk_i, rst_ni, out_valid_o |-> cal_year_o >= 11'd1970 && cal_year_o <= 11'd2038 && cal_month_o >= 4'd1 && cal_month_o <= 4'd12 && cal_day_o >= 5'd1 && hour_of_day_o <= 5'd23 && minute_of_hour_o <= 6'd59 && second_of_minute_o <= 6'd59, "result field out of range")

  `UTC_ASSERT_RST(a_short_month, clk_i, rst_ni, out_valid_o && (cal_month_o == 4'd4 || cal_month_o == 4'd6 || cal_month_o == 4'd9 || cal_month_o == 4'd11) |-> cal_day_o <= 5'd30, "day beyond end of a thirty-day month")

  `UTC_ASSERT_RST(a_february, clk_i, rst_ni, out_valid_o && cal_month_o == 4'd2 |-> cal_day_o <= 5'd28 || (cal_day_o == 5'd29 && cal_year_o[1:0] == 2'b00), "bad February day")

  `UTC_ASSERT_RST(a_no_stall, clk_i, rst_ni, out_ready_i |-> in_ready_o || !in_seen, "input stalled while output is drained")

endmodule

bind unix_time_to_calendar utc_checker u_utc_checker (.*);

`default_nettype wire
